// ===== hw/rtl/mpq_pkg.sv =====
// package for the multilevel priority queue with tag flush
// shared types, op and status codes; no dependencies
`default_nettype none
package mpq_pkg;
  localparam int unsigned NumLevelsDef  = 8;
  localparam int unsigned MaxEntriesDef = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned TagW  = 32;
  localparam int unsigned LvlW  = 4;
  localparam int unsigned CntW  = 7;
  localparam int unsigned OpW   = 3;

  typedef enum logic [OpW-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [DataW-1:0] data;
    logic [LvlW-1:0]  priority_req;
    logic [TagW-1:0]  tag;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             has_data;
    logic [DataW-1:0] data_out;
    logic [CntW-1:0]  removed_count;
    logic [CntW-1:0]  count;
  } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mpq_if.sv =====
// valid/ready channel interfaces for requests and responses
// no dependencies
`default_nettype none
interface mpq_req_if;
  logic valid;
  logic ready;
  logic [2:0]  op;
  logic [31:0] data;
  logic [3:0]  priority_req;
  logic [31:0] tag;
  modport source (output valid, op, data, priority_req, tag, input ready);
  modport sink (input valid, op, data, priority_req, tag, output ready);
endinterface

interface mpq_rsp_if;
  logic valid;
  logic ready;
  logic [1:0]  status;
  logic        has_data;
  logic [31:0] data_out;
  logic [6:0]  removed_count;
  logic [6:0]  count;
  modport source (output valid, status, has_data, data_out, removed_count, count,
                  input ready);
  modport sink (input valid, status, has_data, data_out, removed_count, count,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mpq_front.sv =====
// front end: accepts request beats into a two-entry queue
// depends on mpq_pkg
`default_nettype none
module mpq_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mpq_pkg::req_t in_req_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output mpq_pkg::req_t      q_req_o
);
  import mpq_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("queue lost a beat");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q) else $error("pointer skew");
endmodule
`default_nettype wire

// ===== hw/rtl/mpq_back.sv =====
// back end: slot store, scanning sequencer and response register
// depends on mpq_pkg
`default_nettype none
module mpq_back #(
  parameter int unsigned NumLevels  = mpq_pkg::NumLevelsDef,
  parameter int unsigned MaxEntries = mpq_pkg::MaxEntriesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [6:0]    max_cap_i,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  wire mpq_pkg::req_t q_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mpq_pkg::rsp_t      out_rsp_o
);
  import mpq_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned EntW = $clog2(MaxEntries + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  logic [MaxEntries-1:0] valid_q;
  logic [DataW-1:0] dmem [MaxEntries];
  logic [TagW-1:0]  tmem [MaxEntries];
  logic [LvlW-1:0]  lmem [MaxEntries];
  logic [63:0]      amem [MaxEntries];

  logic [1:0]      state_q;
  req_t            req_q;
  logic [IdxW-1:0] idx_q;
  logic [63:0]     arr_q;
  logic [EntW-1:0] cnt_q, rem_q;
  logic            best_v_q, free_v_q;
  logic [IdxW-1:0] best_q, free_q;
  logic [LvlW-1:0] best_l_q;
  logic [63:0]     best_a_q;
  logic [DataW-1:0] best_d_q;
  rsp_t            rsp_q;
  logic            ov_q;

  // registered slot read, compared in the cycle after the address is issued
  logic            cmp_v_q;
  logic [IdxW-1:0] sidx_q;
  logic [LvlW-1:0] rl_q;
  logic [63:0]     ra_q;
  logic [DataW-1:0] rd_q;
  logic [TagW-1:0] rt_q;

  logic            last, better;
  logic [EntW-1:0] cap;
  rsp_t            rsp_d;
  logic [EntW-1:0] cnt_d;

  assign last = (idx_q == IdxW'(MaxEntries - 1));
  assign better = cmp_v_q && valid_q[sidx_q] && (!best_v_q || rl_q > best_l_q ||
                  (rl_q == best_l_q && ra_q < best_a_q));
  assign cap = ({25'd0, max_cap_i} < 32'(MaxEntries)) ? EntW'(max_cap_i)
                                                      : EntW'(MaxEntries);

  assign q_ready_o   = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_rsp_o   = rsp_q;

  always_comb begin
    rsp_d = '0;
    cnt_d = cnt_q;
    unique case (req_q.op)
      OP_PUSH: begin
        if (req_q.data == '0 || 32'(req_q.priority_req) >= 32'(NumLevels))
          rsp_d.status = ST_INVALID;
        else if (cnt_q >= cap || !free_v_q) rsp_d.status = ST_FULL;
        else cnt_d = cnt_q + 1'b1;
      end
      OP_POP, OP_PEEK: begin
        if (!best_v_q) rsp_d.status = ST_EMPTY;
        else begin
          rsp_d.has_data = 1'b1;
          rsp_d.data_out = best_d_q;
          if (req_q.op == OP_POP && cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end
      OP_REMOVE: begin
        rsp_d.removed_count = CntW'(rem_q);
        cnt_d = (cnt_q >= rem_q) ? cnt_q - rem_q : '0;
      end
      OP_CLEAR: begin
        rsp_d.removed_count = CntW'(rem_q);
        cnt_d = '0;
      end
      default: rsp_d.status = ST_INVALID;
    endcase
    rsp_d.count = CntW'(cnt_d);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) req_q <= q_req_i;
    if (state_q == S_SCAN) begin
      sidx_q <= idx_q;
      rl_q <= lmem[idx_q]; ra_q <= amem[idx_q];
      rd_q <= dmem[idx_q]; rt_q <= tmem[idx_q];
    end
    if (better) begin
      best_l_q <= rl_q; best_a_q <= ra_q; best_d_q <= rd_q;
      best_q <= sidx_q;
    end
    if (cmp_v_q && !valid_q[sidx_q] && !free_v_q) free_q <= sidx_q;
    if (state_q == S_DONE && !ov_q && req_q.op == OP_PUSH && rsp_d.status == ST_OK)
    begin
      dmem[free_q] <= req_q.data;
      tmem[free_q] <= req_q.tag;
      lmem[free_q] <= req_q.priority_req;
      amem[free_q] <= arr_q;
    end
    if (state_q == S_DONE && !ov_q) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; idx_q <= '0; valid_q <= '0; arr_q <= '0;
      cnt_q <= '0; rem_q <= '0; best_v_q <= 1'b0; free_v_q <= 1'b0; ov_q <= 1'b0;
      cmp_v_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      cmp_v_q <= (state_q == S_SCAN);
      if (cmp_v_q) begin
        if (better) best_v_q <= 1'b1;
        if (!valid_q[sidx_q]) free_v_q <= 1'b1;
        if (valid_q[sidx_q] && (req_q.op == OP_CLEAR ||
            (req_q.op == OP_REMOVE && rt_q == req_q.tag))) begin
          valid_q[sidx_q] <= 1'b0;
          rem_q <= rem_q + 1'b1;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            state_q <= S_SCAN; idx_q <= '0; rem_q <= '0;
            best_v_q <= 1'b0; free_v_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (last) state_q <= S_TAIL;
          else idx_q <= idx_q + 1'b1;
        end
        S_TAIL: state_q <= S_DONE;
        S_DONE: begin
          if (!ov_q) begin
            ov_q <= 1'b1;
            cnt_q <= cnt_d;
            state_q <= S_IDLE;
            if (req_q.op == OP_PUSH && rsp_d.status == ST_OK) begin
              valid_q[free_q] <= 1'b1;
              arr_q <= arr_q + 64'd1;
            end
            if (req_q.op == OP_POP && best_v_q) valid_q[best_q] <= 1'b0;
            if (req_q.op == OP_CLEAR) arr_q <= '0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> 32'($countones(valid_q)) == 32'(cnt_q))
    else $error("count out of step with valid bits");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(rsp_q)) else $error("response lost");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
endmodule
`default_nettype wire

// ===== hw/rtl/multilevel_priority_queue_tag_flush_unit.sv =====
// Multilevel priority queue with tag flush. The back end serves each request
// beat with one registered slot read per cycle through a single scan that finds
// the head, a free slot and tag matches, then a tail state to compare the last
// slot, then the done state; a front queue stage sits ahead of it, and a
// response register lets the next request start while a result waits.
// Depends on mpq_pkg, mpq_if, mpq_front and mpq_back.
`default_nettype none
module multilevel_priority_queue_tag_flush_unit #(
  parameter int unsigned NumLevels  = mpq_pkg::NumLevelsDef,
  parameter int unsigned MaxEntries = mpq_pkg::MaxEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mpq_req_if.sink          req,
  mpq_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mpq_pkg::*;

  logic [6:0] max_cap_q;
  req_t in_req, q_req;
  rsp_t out_rsp;
  logic q_valid, q_ready;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, max_cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_cap_q <= 7'd64;
    else if (psel && penable && pwrite && paddr == 2'd0) max_cap_q <= pwdata[6:0];
  end

  assign in_req.op = req.op;
  assign in_req.data = req.data;
  assign in_req.priority_req = req.priority_req;
  assign in_req.tag = req.tag;

  mpq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_req_i(in_req),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  mpq_back #(.NumLevels(NumLevels), .MaxEntries(MaxEntries)) u_back (
    .clk_i, .rst_ni, .max_cap_i(max_cap_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .out_rsp_o(out_rsp)
  );

  assign rsp.status = out_rsp.status;
  assign rsp.has_data = out_rsp.has_data;
  assign rsp.data_out = out_rsp.data_out;
  assign rsp.removed_count = out_rsp.removed_count;
  assign rsp.count = out_rsp.count;
endmodule
`default_nettype wire

// ===== tb/sv/mpq_tb_checker.sv =====
`timescale 1ns / 1ps
// response checker for the multilevel priority queue with tag flush
// watches the request and response channels, predicts each response, compares
// depends on mpq_pkg
module mpq_tb_checker #(
  parameter int unsigned NumLevels  = 8,
  parameter int unsigned MaxEntries = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  input  wire logic        req_ready_i,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] data_i,
  input  wire logic [3:0]  priority_req_i,
  input  wire logic [31:0] tag_i,
  input  wire logic        rsp_valid_i,
  input  wire logic        rsp_ready_i,
  input  wire logic [1:0]  status_i,
  input  wire logic        has_data_i,
  input  wire logic [31:0] data_out_i,
  input  wire logic [6:0]  removed_count_i,
  input  wire logic [6:0]  count_i,
  input  wire logic        cfg_we_i,
  input  wire logic [6:0]  cfg_capacity_i,
  output int               errors_o,
  output int               pending_o
);
  import mpq_pkg::*;

  logic [6:0]  capacity_q;
  logic        slot_used[MaxEntries];
  logic [31:0] slot_word[MaxEntries];
  logic [31:0] slot_grp[MaxEntries];
  logic [3:0]  slot_lvl[MaxEntries];
  logic [63:0] slot_seq[MaxEntries];
  logic [63:0] seq_next;
  int unsigned held;
  rsp_t        rsp_expected_q[$];

  function automatic int head_slot();
    int best;
    best = -1;
    for (int i = 0; i < MaxEntries; i++) begin
      if (slot_used[i] && (best < 0 || slot_lvl[i] > slot_lvl[best] ||
          (slot_lvl[i] == slot_lvl[best] && slot_seq[i] < slot_seq[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic rsp_t queue_apply(logic [2:0] op, logic [31:0] data,
                                       logic [3:0] lvl, logic [31:0] tag);
    rsp_t r;
    int unsigned lim;
    int h;
    int f;
    r = '0;
    r.status = ST_OK;
    lim = (capacity_q < MaxEntries) ? capacity_q : MaxEntries;
    case (op)
      OP_PUSH: begin
        if (data == 0 || lvl >= NumLevels) r.status = ST_INVALID;
        else if (held >= lim) r.status = ST_FULL;
        else begin
          f = -1;
          for (int i = MaxEntries - 1; i >= 0; i--) if (!slot_used[i]) f = i;
          if (f < 0) r.status = ST_FULL;
          else begin
            slot_used[f] = 1'b1;
            slot_word[f] = data;
            slot_grp[f]  = tag;
            slot_lvl[f]  = lvl;
            slot_seq[f]  = seq_next;
            seq_next++;
            held++;
          end
        end
      end
      OP_POP, OP_PEEK: begin
        h = head_slot();
        if (h < 0) r.status = ST_EMPTY;
        else begin
          r.has_data = 1'b1;
          r.data_out = slot_word[h];
          if (op == OP_POP) begin
            slot_used[h] = 1'b0;
            if (held > 0) held--;
          end
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < MaxEntries; i++)
          if (slot_used[i] && slot_grp[i] == tag) begin
            slot_used[i] = 1'b0;
            r.removed_count++;
          end
        held = (held >= r.removed_count) ? held - r.removed_count : 0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < MaxEntries; i++)
          if (slot_used[i]) begin
            slot_used[i] = 1'b0;
            r.removed_count++;
          end
        held = 0;
        seq_next = '0;
      end
      default: r.status = ST_INVALID;
    endcase
    r.count = held[6:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t got;
    rsp_t exp_rsp;
    if (!rst_ni) begin
      capacity_q <= 7'd64;
      for (int i = 0; i < MaxEntries; i++) slot_used[i] = 1'b0;
      seq_next = '0;
      held = 0;
      rsp_expected_q.delete();
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) capacity_q <= cfg_capacity_i;
      if (rsp_valid_i && rsp_ready_i) begin
        got = '{status_i, has_data_i, data_out_i, removed_count_i, count_i};
        if (rsp_expected_q.size() == 0) begin
          $display("%0t: unexpected response beat %h", $realtime, got);
          errors_o <= errors_o + 1;
        end else begin
          exp_rsp = rsp_expected_q.pop_front();
          if (got != exp_rsp) begin
            $display("%0t: mismatch expected st=%0d hd=%0d d=%h rm=%0d cnt=%0d",
                     $realtime, exp_rsp.status, exp_rsp.has_data, exp_rsp.data_out,
                     exp_rsp.removed_count, exp_rsp.count);
            $display("%0t:          actual   st=%0d hd=%0d d=%h rm=%0d cnt=%0d",
                     $realtime, got.status, got.has_data, got.data_out,
                     got.removed_count, got.count);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i)
        rsp_expected_q.push_back(queue_apply(op_i, data_i, priority_req_i, tag_i));
      pending_o <= rsp_expected_q.size();
    end
  end
endmodule

// ===== tb/sv/tb_multilevel_priority_queue_tag_flush_unit.sv =====
`timescale 1ns / 1ps
// testbench top for the multilevel priority queue with tag flush
// drives requests, capacity writes and response stalls; verdict from mpq_tb_checker
module tb_multilevel_priority_queue_tag_flush_unit;
  import mpq_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  bit          no_idle;
  bit          hold_off;
  int          idle_cycles;

  mpq_req_if req ();
  mpq_rsp_if rsp ();

  multilevel_priority_queue_tag_flush_unit u_dut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mpq_tb_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req.valid), .req_ready_i(req.ready), .op_i(req.op),
    .data_i(req.data), .priority_req_i(req.priority_req), .tag_i(req.tag),
    .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .status_i(rsp.status),
    .has_data_i(rsp.has_data), .data_out_i(rsp.data_out),
    .removed_count_i(rsp.removed_count), .count_i(rsp.count),
    .cfg_we_i(psel && penable && pwrite && pready && paddr == 2'd0),
    .cfg_capacity_i(pwdata[6:0]),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver stalls
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) rsp.ready <= 1'b0;
      else rsp.ready <= no_idle || ($urandom_range(99) >= 26);
    end
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic capacity_write(logic [6:0] cap);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {25'd0, cap};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_queue();
    req.valid <= 1'b0;
    while (pending != 0 || req.valid) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_beat(logic [2:0] op, logic [31:0] data, logic [3:0] lvl,
                           logic [31:0] tag);
    while (!no_idle && $urandom_range(99) < 26) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.op <= op; req.data <= data; req.priority_req <= lvl; req.tag <= tag;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic random_beats(int n, int tag_span);
    logic [2:0] op;
    logic [31:0] data;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) op = OP_PUSH;
      else if (pick < 72) op = OP_POP;
      else if (pick < 84) op = OP_PEEK;
      else if (pick < 94) op = OP_REMOVE;
      else if (pick < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(7, 5));
      data = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
      send_beat(op, data,
                ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7)),
                ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(tag_span)));
    end
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req.valid = 1'b0; req.op = '0; req.data = '0; req.priority_req = '0; req.tag = '0;
    no_idle = 1'b0; hold_off = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_beat(OP_POP, 0, 0, 0);
    send_beat(OP_PEEK, 0, 0, 0);
    send_beat(OP_PUSH, 32'd0, 3, 1);
    send_beat(OP_PUSH, 32'hFFFF_FFFF, 4'd8, 1);
    send_beat(OP_PUSH, 32'hFFFF_FFFF, 4'd15, 1);
    send_beat(OP_PUSH, 32'h1, 0, 32'hFFFF_FFFF);
    send_beat(OP_PUSH, 32'hFFFF_FFFF, 7, 32'h0);
    send_beat(OP_PUSH, 32'hAAAA_5555, 7, 32'h0);
    send_beat(OP_PUSH, 32'h5555_AAAA, 3, 32'h0);
    send_beat(OP_PEEK, 0, 0, 0);
    send_beat(OP_POP, 0, 0, 0);
    send_beat(OP_REMOVE, 0, 0, 32'h0);
    send_beat(OP_REMOVE, 0, 0, 32'h1234);
    send_beat(3'd5, 0, 0, 0);
    send_beat(3'd7, 0, 0, 0);
    send_beat(OP_POP, 0, 0, 0);
    send_beat(OP_CLEAR, 0, 0, 0);
    drain_queue();

    capacity_write(7'd0);
    send_beat(OP_PUSH, 32'h77, 2, 5);
    drain_queue();
    capacity_write(7'd1);
    send_beat(OP_PUSH, 32'h11, 2, 5);
    send_beat(OP_PUSH, 32'h22, 2, 5);
    drain_queue();
    capacity_write(7'd127);

    // fill past capacity while the receiver holds off
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 70; i++)
        send_beat(OP_PUSH, $urandom | 1, 4'($urandom_range(7)), 32'(i % 4));
    join
    drain_queue();

    no_idle = 1'b1;
    random_beats(150, 7);
    no_idle = 1'b0;
    random_beats(250, 15);
    drain_queue();
    capacity_write(7'd5);
    random_beats(150, 3);
    drain_queue();
    capacity_write(7'd64);
    random_beats(220, 15);
    drain_queue();

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
